// File: rtl/mrpt_pkg.sv
// Shared constants and types of the memory region pattern test unit.
package mrpt_pkg;

	// Address width of the test engine
	localparam int ADDR_BITS_DEF = 32;

	// Payload field widths
	localparam int OUT_ADDR_W = 32;
	localparam int DATA_W     = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 80;

	// Engine phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_WRITE  = 2'd1;
	localparam logic [1:0] PH_VERIFY = 2'd2;
	localparam logic [1:0] PH_ZERO   = 2'd3;

	// Memory access codes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Completion status codes
	localparam logic [1:0] ST_PASS       = 2'd0;
	localparam logic [1:0] ST_MISMATCH   = 2'd1;
	localparam logic [1:0] ST_NOT_SERVED = 2'd2;

	// Region served limit
	localparam logic [1:0] REGION_LAST = 2'd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_R0_BEGIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_R0_END   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_R1_BEGIN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R1_END   = 8'd3;

	// Pattern byte limits
	localparam logic [DATA_W-1:0] PAT_MAX = 8'd255;
	localparam logic [DATA_W-1:0] PAT_MIN = 8'd0;

	// One result transaction
	typedef struct packed {
		logic [OUT_ADDR_W-1:0] fail_addr;
		logic [1:0]            status;
		logic [DATA_W-1:0]     mem_wdata;
		logic [OUT_ADDR_W-1:0] mem_addr;
		logic [1:0]            mem_op;
	} result_t;

endpackage

// File: rtl/memory_region_pattern_test_unit.sv
// Memory region pattern test engine: write, verify and zero a byte region.
//
// Usage: each transaction on the s_ stream is one engine tick carrying start_req,
// region and the read data for the read issued on the previous tick. Every tick
// yields exactly one m_ transaction with the memory access to perform (none,
// write or read), its address and write byte, plus completion status; m_tlast
// marks the tick on which a test finishes. A start on region 0 or 1 latches
// that region's begin and exclusive end address from the configuration
// registers, writes a 0..255..0 triangle pattern, reads it back checking each
// byte, stops on the first mismatch, and otherwise clears the region to zero.
// Regions 2 and 3 finish at once with status not served.
// Configuration writes on the cfg_ channel are always taken (index 0..3).
// Result: a tick's result is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per cycle while results are taken; all work of a tick is one combinational step
// from the engine state registers into the result register.
// Receiver stall: the result register holds; one further tick is refused until
// the result is taken, so s_tready follows m_tready when a result is waiting.
// Reset: the engine returns to idle, configuration and engine registers clear to zero, no result valid.
module memory_region_pattern_test_unit #(
	parameter int ADDR_BITS = mrpt_pkg::ADDR_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tick input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mrpt_pkg::IN_TDATA_W-1:0]      s_tdata,  // start_req, region[2], read_data[8]
	// result output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mrpt_pkg::OUT_TDATA_W-1:0]     m_tdata,  // mem_op[2], mem_addr[32],
	                                                       // mem_wdata[8], status[2],
	                                                       // fail_addr[32]
	output logic                                 m_tlast,  // done_res
	// configuration write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mrpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mrpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW = mrpt_pkg::DATA_W;

	// Unpack input tick
	logic          start_req;
	logic [1:0]    region;
	logic [DW-1:0] read_data;
	assign start_req = s_tdata[0];
	assign region    = s_tdata[2:1];
	assign read_data = s_tdata[3 +: DW];

	// Configuration registers
	logic [ADDR_BITS-1:0] r0_begin_q, r0_end_q, r1_begin_q, r1_end_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_begin_q <= '0;
			r0_end_q   <= '0;
			r1_begin_q <= '0;
			r1_end_q   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == mrpt_pkg::REG_R0_BEGIN) r0_begin_q <= cfg_data[ADDR_BITS-1:0];
			if (cfg_index == mrpt_pkg::REG_R0_END)   r0_end_q   <= cfg_data[ADDR_BITS-1:0];
			if (cfg_index == mrpt_pkg::REG_R1_BEGIN) r1_begin_q <= cfg_data[ADDR_BITS-1:0];
			if (cfg_index == mrpt_pkg::REG_R1_END)   r1_end_q   <= cfg_data[ADDR_BITS-1:0];
		end
	end

	// Engine state
	logic [1:0]           phase_q;
	logic [ADDR_BITS-1:0] cur_q, end_q, begin_q, pend_addr_q;
	logic [DW-1:0]        pat_q, pend_exp_q;
	logic                 pat_down_q, rd_pend_q;

	logic [1:0]           phase_d;
	logic [ADDR_BITS-1:0] cur_d, end_d, begin_d, pend_addr_d;
	logic [DW-1:0]        pat_d, pend_exp_d;
	logic                 pat_down_d, rd_pend_d;
	mrpt_pkg::result_t    res_d;
	logic                 done_d;

	// Shared step terms
	logic                 in_range;
	logic [ADDR_BITS-1:0] cur_inc;
	logic [DW-1:0]        pat_adv;
	logic                 pat_down_adv;

	assign in_range = cur_q < end_q;
	assign cur_inc  = cur_q + 1'b1;

	// Advance the triangle pattern
	always_comb begin
		pat_adv      = pat_q;
		pat_down_adv = pat_down_q;
		if (!pat_down_q) begin
			if (pat_q != mrpt_pkg::PAT_MAX) pat_adv = pat_q + 1'b1;
			else pat_down_adv = 1'b1;
		end else begin
			if (pat_q != mrpt_pkg::PAT_MIN) pat_adv = pat_q - 1'b1;
			else pat_down_adv = 1'b0;
		end
	end

	// Compute one engine tick
	always_comb begin
		phase_d     = phase_q;
		cur_d       = cur_q;
		end_d       = end_q;
		begin_d     = begin_q;
		pat_d       = pat_q;
		pat_down_d  = pat_down_q;
		rd_pend_d   = rd_pend_q;
		pend_addr_d = pend_addr_q;
		pend_exp_d  = pend_exp_q;
		res_d       = '0;
		done_d      = 1'b0;
		unique case (phase_q)
			mrpt_pkg::PH_IDLE: begin
				if (start_req) begin
					if (region > mrpt_pkg::REGION_LAST) begin
						done_d       = 1'b1;
						res_d.status = mrpt_pkg::ST_NOT_SERVED;
					end else begin
						begin_d    = region[0] ? r1_begin_q : r0_begin_q;
						end_d      = region[0] ? r1_end_q   : r0_end_q;
						cur_d      = begin_d;
						pat_d      = '0;
						pat_down_d = 1'b0;
						rd_pend_d  = 1'b0;
						phase_d    = mrpt_pkg::PH_WRITE;
					end
				end
			end
			mrpt_pkg::PH_WRITE: begin
				if (in_range) begin
					res_d.mem_op    = mrpt_pkg::OP_WRITE;
					res_d.mem_addr  = mrpt_pkg::OUT_ADDR_W'(cur_q);
					res_d.mem_wdata = pat_q;
					pat_d           = pat_adv;
					pat_down_d      = pat_down_adv;
					cur_d           = cur_inc;
				end else begin
					cur_d      = begin_q;
					pat_d      = '0;
					pat_down_d = 1'b0;
					rd_pend_d  = 1'b0;
					phase_d    = mrpt_pkg::PH_VERIFY;
				end
			end
			mrpt_pkg::PH_VERIFY: begin
				rd_pend_d = 1'b0;
				if (rd_pend_q && (read_data != pend_exp_q)) begin
					done_d          = 1'b1;
					res_d.status    = mrpt_pkg::ST_MISMATCH;
					res_d.fail_addr = mrpt_pkg::OUT_ADDR_W'(pend_addr_q);
					phase_d         = mrpt_pkg::PH_IDLE;
				end else if (in_range) begin
					res_d.mem_op   = mrpt_pkg::OP_READ;
					res_d.mem_addr = mrpt_pkg::OUT_ADDR_W'(cur_q);
					pend_addr_d    = cur_q;
					pend_exp_d     = pat_q;
					rd_pend_d      = 1'b1;
					pat_d          = pat_adv;
					pat_down_d     = pat_down_adv;
					cur_d          = cur_inc;
				end else begin
					cur_d   = begin_q;
					phase_d = mrpt_pkg::PH_ZERO;
				end
			end
			mrpt_pkg::PH_ZERO: begin
				if (in_range) begin
					res_d.mem_op   = mrpt_pkg::OP_WRITE;
					res_d.mem_addr = mrpt_pkg::OUT_ADDR_W'(cur_q);
					cur_d          = cur_inc;
				end else begin
					done_d       = 1'b1;
					res_d.status = mrpt_pkg::ST_PASS;
					phase_d      = mrpt_pkg::PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	// Accept a tick when the result register is free or being drained
	logic              s_acc;
	logic              m_valid_q;
	mrpt_pkg::result_t res_q;
	logic              done_q;

	assign s_tready = !m_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	// Hold engine state, advance on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mrpt_pkg::PH_IDLE;
			cur_q       <= '0;
			end_q       <= '0;
			begin_q     <= '0;
			pat_q       <= '0;
			pat_down_q  <= 1'b0;
			rd_pend_q   <= 1'b0;
			pend_addr_q <= '0;
			pend_exp_q  <= '0;
		end else if (s_acc) begin
			phase_q     <= phase_d;
			cur_q       <= cur_d;
			end_q       <= end_d;
			begin_q     <= begin_d;
			pat_q       <= pat_d;
			pat_down_q  <= pat_down_d;
			rd_pend_q   <= rd_pend_d;
			pend_addr_q <= pend_addr_d;
			pend_exp_q  <= pend_exp_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			res_q  <= res_d;
			done_q <= done_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {4'b0, res_q};

	// A tick accepted always leaves a result waiting
	a_acc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_tvalid)
		else $error("accepted tick produced no result");

	// A finishing tick makes no memory access
	a_done_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && done_d) |-> (res_d.mem_op == mrpt_pkg::OP_NONE))
		else $error("access issued on finishing tick");

	// Nonpass status only on a finishing tick
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (res_d.status != mrpt_pkg::ST_PASS)) |-> done_d)
		else $error("status without completion");

	// No read outstanding while idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mrpt_pkg::PH_IDLE) |-> !rd_pend_q)
		else $error("read pending while idle");

	// Reads are only issued in the verify phase
	a_read_in_verify: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (res_d.mem_op == mrpt_pkg::OP_READ)) |-> (phase_q == mrpt_pkg::PH_VERIFY))
		else $error("read outside verify phase");

endmodule
